### rtl/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg: shared types and constants of the edit distance engine
// Sizes, the item kind codes, the token passed along the cell chain and the
// control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package ede_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int IDX_W       = $clog2(MAX_PATTERN + 1);
   localparam int SYM_W       = 8;
   localparam int DIST_W      = 16;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef enum logic {
      KIND_PATTERN = 1'b0,
      KIND_QUERY   = 1'b1
   } req_kind_type;

   // One query symbol (or a read of the final distance) moving down the chain.
   typedef struct packed {
      logic              valid;
      logic              has_sym;
      logic              last;
      logic [SYM_W-1:0]  sym;
      logic [DIST_W-1:0] diag;
      logic [DIST_W-1:0] left;
      logic [DIST_W-1:0] answer;
   } token_type;

   typedef struct packed {
      logic              advance;
      logic              clear_row;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_index;
      logic [SYM_W-1:0]  wr_sym;
      logic [IDX_W-1:0]  len;
   } cell_ctrl_type;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
      sat_inc = (v == DIST_MAX) ? DIST_MAX : v + 1'b1;
   endfunction

endpackage

### rtl/ede_cell.sv
// ----------------------------------------------------------------------------
// ede_cell: one column of the distance row
// Holds one pattern symbol and one row entry; updates the entry when a query
// token passes and hands the token on to the next column through its register.
// ----------------------------------------------------------------------------
module ede_cell
   import ede_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  cell_ctrl_type    ctrl,
   input  token_type        tok_in,
   output token_type        tok_out
);

   logic [DIST_W-1:0] row_ff, row_in;
   logic [SYM_W-1:0]  pat_ff, pat_in;
   token_type         tok_ff, tok_nx_in;

   logic [DIST_W-1:0] row_init;
   logic [DIST_W-1:0] best;
   logic [DIST_W-1:0] new_val;

   assign row_init = {{(DIST_W - IDX_W){1'b0}}, cell_index};
   assign tok_out  = tok_ff;

   always_comb begin
      best = tok_in.diag;
      if (row_ff < best) begin
         best = row_ff;
      end
      if (tok_in.left < best) begin
         best = tok_in.left;
      end
      if (!tok_in.has_sym) begin
         new_val = row_ff;
      end else if (pat_ff == tok_in.sym) begin
         new_val = tok_in.diag;
      end else begin
         new_val = sat_inc(best);
      end
   end

   always_comb begin
      pat_in    = pat_ff;
      row_in    = row_ff;
      tok_nx_in = tok_ff;
      if (ctrl.wr_en && (ctrl.wr_index == cell_index)) begin
         pat_in = ctrl.wr_sym;
      end
      if (ctrl.advance) begin
         tok_nx_in.valid   = tok_in.valid;
         tok_nx_in.has_sym = tok_in.has_sym;
         tok_nx_in.last    = tok_in.last;
         tok_nx_in.sym     = tok_in.sym;
         tok_nx_in.diag    = row_ff;
         tok_nx_in.left    = new_val;
         tok_nx_in.answer  = (tok_in.last && (cell_index == ctrl.len)) ? new_val
                                                                      : tok_in.answer;
         // a closing token resets this column behind it for the next query
         if (tok_in.valid) begin
            row_in = tok_in.last ? row_init : new_val;
         end
      end
      if (ctrl.clear_row) begin
         row_in = row_init;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (reset) begin
         row_ff       <= row_init;
         tok_ff       <= '0;
      end else begin
         row_ff <= row_in;
         tok_ff <= tok_nx_in;
      end
   end

endmodule

### rtl/edit_distance_engine.sv
// Path: a closing query transfer yields its distance after passing the input
//   stage, the head stage, one stage per column and the output stage.
// Throughput: one query transfer per cycle while the output is not stalled, set
//   by the column chain; a pattern transfer waits until the chain is drained.
// Reset: synchronous, active high; clears pattern length and the row, which
//   then holds j in column j. Pattern symbols are undefined until loaded.
// ----------------------------------------------------------------------------
// edit_distance_engine: Levenshtein distance over a systolic column chain
// Pattern transfers fill the column symbols; query symbols travel down the chain
// as a wavefront, one column per cycle unless the output stalls, and a closing query
// transfer picks up the distance at the pattern length and resets the row behind it.
// ----------------------------------------------------------------------------
module edit_distance_engine
   import ede_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] symbol, [8] carries_symbol, rest zero
   input  logic        req_tuser,   // [0] req_type
   input  logic        req_tlast,   // last

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] distance, [16] pattern_overflow, rest zero
);

   // ---------------------------------------------------------------- input stage
   logic              in_valid_ff, in_valid_in;
   req_kind_type      in_kind_ff;
   logic [SYM_W-1:0]  in_sym_ff;
   logic              in_has_sym_ff;
   logic              in_last_ff;

   logic              advance;
   logic              chain_empty;
   logic              issue_query;
   logic              issue_pattern;

   // Hold a transfer until the chain can take it: queries need a moving chain,
   // pattern writes need every column idle so in-flight queries see old symbols.
   assign issue_query   = in_valid_ff && (in_kind_ff == KIND_QUERY) && advance;
   assign issue_pattern = in_valid_ff && (in_kind_ff == KIND_PATTERN) && chain_empty;
   assign req_tready    = !in_valid_ff || issue_query || issue_pattern;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (issue_query || issue_pattern) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff    <= req_kind_type'(req_tuser);
         in_sym_ff     <= req_tdata[SYM_W-1:0];
         in_has_sym_ff <= req_tdata[SYM_W];
         in_last_ff    <= req_tlast;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // ------------------------------------------------------------ pattern control
   logic [IDX_W-1:0] load_count_ff, load_count_in;
   logic [IDX_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] load_next;
   logic             wr_en;
   logic             clear_row;

   always_comb begin
      load_count_in = load_count_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      load_next     = load_count_ff;
      wr_en         = 1'b0;
      clear_row     = 1'b0;
      if (issue_pattern) begin
         // a fresh load starts with a clean overflow flag
         if (load_count_ff == '0) begin
            ovf_in = 1'b0;
         end
         if (in_has_sym_ff) begin
            if (load_count_ff < IDX_W'(MAX_PATTERN)) begin
               wr_en     = 1'b1;
               load_next = load_count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         if (in_last_ff) begin
            // commit: new length, abandon any query and reset the row
            len_in        = load_next;
            load_count_in = '0;
            clear_row     = 1'b1;
         end else begin
            load_count_in = load_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
      end
   end

   // ------------------------------------------------------------------ head column
   // Column zero counts query symbols; it launches each token with the old and
   // new value of that entry as the diagonal and left neighbors of column one.
   logic [DIST_W-1:0] row0_ff, row0_in;
   logic [DIST_W-1:0] row0_new;
   token_type         tok0_ff, tok0_in;

   assign row0_new = in_has_sym_ff ? sat_inc(row0_ff) : row0_ff;

   always_comb begin
      row0_in = row0_ff;
      tok0_in = tok0_ff;
      if (advance) begin
         tok0_in.valid   = issue_query;
         tok0_in.has_sym = in_has_sym_ff;
         tok0_in.last    = in_last_ff;
         tok0_in.sym     = in_sym_ff;
         tok0_in.diag    = row0_ff;
         tok0_in.left    = row0_new;
         tok0_in.answer  = row0_new;   // the answer for an empty pattern
      end
      if (issue_query) begin
         row0_in = in_last_ff ? '0 : row0_new;
      end
      if (clear_row) begin
         row0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= '0;
         tok0_ff <= '0;
      end else begin
         row0_ff <= row0_in;
         tok0_ff <= tok0_in;
      end
   end

   // ------------------------------------------------------------------ column chain
   cell_ctrl_type ctrl;
   token_type     tok [MAX_PATTERN+1];

   assign ctrl.advance   = advance;
   assign ctrl.clear_row = clear_row;
   assign ctrl.wr_en     = wr_en;
   assign ctrl.wr_index  = load_count_ff + 1'b1;   // column j holds pattern symbol j-1
   assign ctrl.wr_sym    = in_sym_ff;
   assign ctrl.len       = len_ff;

   assign tok[0] = tok0_ff;

   for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_col
      ede_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(j)),
         .ctrl       (ctrl),
         .tok_in     (tok[j-1]),
         .tok_out    (tok[j])
      );
   end

   always_comb begin
      chain_empty = 1'b1;
      for (int k = 0; k <= MAX_PATTERN; k++) begin
         if (tok[k].valid) begin
            chain_empty = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- output stage
   // Stall the whole chain while a finished distance waits to be taken.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_ovf_ff;

   assign advance = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = tok[MAX_PATTERN].valid && tok[MAX_PATTERN].last;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_dist_ff <= tok[MAX_PATTERN].answer;
         rsp_ovf_ff  <= ovf_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ovf_ff, rsp_dist_ff};

endmodule

### tb/sv/tb_edit_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edit_distance_engine: self-checking bench for the edit distance engine
// Drives pattern and query transfers on the request stream, predicts every
// closing distance with a row-by-row Levenshtein model and checks each
// response transfer against the oldest prediction, under random idling on
// both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine
   import ede_pkg::*;
();

   // One closing query gives one distance.
   localparam int SETTLE_CYCLES = MAX_PATTERN + 8;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } distance_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [7:0] symbol, [8] carries_symbol, rest zero
   logic        req_tuser = 1'b0;  // [0] req_type
   logic        req_tlast = 1'b0;  // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] distance, [16] pattern_overflow, rest zero

   edit_distance_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted state of the engine: pattern store, committed length, load in
   // progress, truncation flag and the current cost row.
   logic [SYM_W-1:0]  pat_mem [MAX_PATTERN];
   logic [DIST_W-1:0] cost_row [MAX_PATTERN + 1];
   int unsigned       pat_len;
   int unsigned       load_cnt;
   logic              ovf_flag;

   distance_result_type pending_distances [$];

   int  items_sent;
   int  results_checked;
   int  failure_count;
   bit  steady_flow;       // both streams run without idling while set
   int  stall_request;     // output hold-off asked for by a test, in cycles
   int  stall_left;
   int  longest_stall;

   function automatic logic [DIST_W-1:0] bump_sat(input logic [DIST_W-1:0] v);
      return (v == DIST_MAX) ? DIST_MAX : v + 1'b1;
   endfunction

   function automatic void clear_cost_row();
      for (int j = 0; j <= MAX_PATTERN; j++)
         cost_row[j] = j[DIST_W-1:0];
   endfunction

   // Advance the row by one query symbol: column j becomes the distance
   // between the longer query prefix and the first j pattern symbols.
   function automatic void advance_cost_row(input logic [SYM_W-1:0] sym);
      logic [DIST_W-1:0] diag, left, up, col_val, m;
      diag        = cost_row[0];
      left        = bump_sat(cost_row[0]);
      cost_row[0] = left;
      for (int j = 1; j <= int'(pat_len); j++) begin
         up = cost_row[j];
         if (pat_mem[j-1] == sym) begin
            col_val = diag;
         end else begin
            m = diag;
            if (up < m) m = up;
            if (left < m) m = left;
            col_val = bump_sat(m);
         end
         diag        = up;
         cost_row[j] = col_val;
         left        = col_val;
      end
   endfunction

   function automatic void predict_item(input req_kind_type kind,
                                        input logic [SYM_W-1:0] sym,
                                        input logic has_sym, input logic last);
      distance_result_type res;
      if (kind == KIND_PATTERN) begin
         // A new load starts with a clean truncation flag.
         if (load_cnt == 0) ovf_flag = 1'b0;
         if (has_sym) begin
            if (load_cnt < MAX_PATTERN) begin
               pat_mem[load_cnt] = sym;
               load_cnt++;
            end else begin
               ovf_flag = 1'b1;
            end
         end
         // Commit abandons any query in progress.
         if (last) begin
            pat_len  = load_cnt;
            load_cnt = 0;
            clear_cost_row();
         end
      end else begin
         if (has_sym) advance_cost_row(sym);
         if (last) begin
            res.distance = cost_row[pat_len];
            res.overflow = ovf_flag;
            pending_distances.push_back(res);
            clear_cost_row();
         end
      end
   endfunction

   function automatic logic [SYM_W-1:0] pick_symbol();
      // Mostly a small alphabet so that matches are common.
      if ($urandom_range(3) != 0) return SYM_W'(8'h61 + $urandom_range(3));
      return SYM_W'($urandom_range(255));
   endfunction

   // Offer one item and hold it until the engine takes it; the prediction
   // runs at the accepting edge.
   task automatic send_item(input req_kind_type kind, input logic [SYM_W-1:0] sym,
                            input logic has_sym, input logic last);
      while (!steady_flow && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, has_sym, sym};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_item(kind, sym, has_sym, last);
   endtask

   // Drop valid, wait for every predicted distance, then let the chain settle
   // so that a stray response would still be caught.
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_failure(input string what);
      failure_count++;
      if (failure_count <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // Output ready: random idling, or a counted hold-off when a test asks.
   always @(posedge clock) begin
      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
         if (stall_left > longest_stall) longest_stall = stall_left;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 11);
      end
   end

   // Compare every response transfer with the oldest prediction.
   always @(posedge clock) begin
      distance_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            note_failure($sformatf("unexpected response, distance %0d overflow %0b",
                                   rsp_tdata[15:0], rsp_tdata[16]));
         end else begin
            want = pending_distances.pop_front();
            results_checked++;
            if (rsp_tdata[15:0] !== want.distance)
               note_failure($sformatf("distance: expected %0d, got %0d",
                                      want.distance, rsp_tdata[15:0]));
            if (rsp_tdata[16] !== want.overflow)
               note_failure($sformatf("pattern_overflow: expected %0b, got %0b",
                                      want.overflow, rsp_tdata[16]));
         end
      end
   end

   // Field extremes, every item kind and the documented corner cases.
   task automatic test_directed_basics();
      // Empty query against the empty pattern left by reset.
      send_item(KIND_QUERY, 8'hFF, 1'b0, 1'b1);
      // Pattern with both extreme bytes, closed on a symbol.
      send_item(KIND_PATTERN, 8'h00, 1'b1, 1'b0);
      send_item(KIND_PATTERN, 8'hFF, 1'b1, 1'b0);
      send_item(KIND_PATTERN, 8'h61, 1'b1, 1'b1);
      // Query closed by an empty item.
      send_item(KIND_QUERY, 8'hFF, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h00, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h5A, 1'b0, 1'b1);
      // Commit an empty pattern, then query it.
      send_item(KIND_PATTERN, 8'hA5, 1'b0, 1'b1);
      send_item(KIND_QUERY, 8'h78, 1'b1, 1'b1);
      // Pattern closed by an empty item; a query is abandoned by a commit.
      send_item(KIND_PATTERN, 8'h61, 1'b1, 1'b0);
      send_item(KIND_PATTERN, 8'h62, 1'b1, 1'b0);
      send_item(KIND_PATTERN, 8'h00, 1'b0, 1'b1);
      send_item(KIND_QUERY, 8'h61, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h00, 1'b0, 1'b0);
      send_item(KIND_PATTERN, 8'h63, 1'b1, 1'b1);
      send_item(KIND_QUERY, 8'h63, 1'b1, 1'b1);
      // Query while a load overwrites the committed symbol.
      send_item(KIND_PATTERN, 8'h78, 1'b1, 1'b0);
      send_item(KIND_PATTERN, 8'h79, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h78, 1'b1, 1'b1);
      send_item(KIND_PATTERN, 8'h7A, 1'b1, 1'b1);
      send_item(KIND_QUERY, 8'h79, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h7A, 1'b1, 1'b1);
      finish_phase();
   endtask

   // Full store, truncation, and the flag as seen in the middle of a load.
   task automatic test_pattern_overflow();
      for (int i = 0; i < MAX_PATTERN; i++)
         send_item(KIND_PATTERN, pick_symbol(), 1'b1, i == MAX_PATTERN - 1);
      for (int i = 0; i < 5; i++) send_item(KIND_QUERY, pick_symbol(), 1'b1, i == 4);
      for (int i = 0; i < MAX_PATTERN + 6; i++)
         send_item(KIND_PATTERN, pick_symbol(), 1'b1, i == MAX_PATTERN + 5);
      for (int i = 0; i < 8; i++) send_item(KIND_QUERY, pick_symbol(), 1'b1, i == 7);
      // A fresh load clears the flag at once.
      send_item(KIND_PATTERN, 8'h61, 1'b1, 1'b0);
      send_item(KIND_PATTERN, 8'h62, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h61, 1'b1, 1'b1);
      send_item(KIND_PATTERN, 8'h63, 1'b1, 1'b1);
      send_item(KIND_QUERY, 8'h61, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h62, 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h63, 1'b1, 1'b1);
      // Overflow inside an open load, seen by a query before the commit.
      for (int i = 0; i < MAX_PATTERN + 2; i++) send_item(KIND_PATTERN, pick_symbol(), 1'b1, 1'b0);
      send_item(KIND_QUERY, 8'h78, 1'b1, 1'b1);
      send_item(KIND_PATTERN, 8'h00, 1'b0, 1'b1);
      send_item(KIND_QUERY, 8'h00, 1'b0, 1'b1);
      finish_phase();
   endtask

   // A long query against a short pattern, so the distance keeps growing.
   task automatic test_long_query();
      send_item(KIND_PATTERN, 8'h00, 1'b1, 1'b0);
      send_item(KIND_PATTERN, 8'h01, 1'b1, 1'b1);
      for (int i = 0; i < 40; i++) send_item(KIND_QUERY, 8'hFF, 1'b1, i == 39);
      finish_phase();
   endtask

   // Hold the output off while closing queries keep coming, so the chain
   // fills and the request side stalls.
   task automatic test_output_backpressure();
      for (int i = 0; i < 10; i++) send_item(KIND_PATTERN, pick_symbol(), 1'b1, i == 9);
      stall_request = 300;
      for (int i = 0; i < 80; i++) send_item(KIND_QUERY, pick_symbol(), 1'b1, 1'b1);
      finish_phase();
   endtask

   // Mostly well-formed loads followed by queries, with some raw noise.
   task automatic test_random_traffic(input int target);
      int start_count, done, plen, nq, qlen, n;
      bit empty_close;
      start_count = items_sent;
      done        = 0;
      while (done < target) begin
         steady_flow = (done >= target / 3) && (done < target / 3 + 120);
         if ($urandom_range(99) < 82) begin
            plen = ($urandom_range(15) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 10);
            empty_close = (plen == 0) || ($urandom_range(2) == 0);
            for (int i = 0; i < plen; i++)
               send_item(KIND_PATTERN, pick_symbol(), 1'b1, !empty_close && i == plen - 1);
            if (empty_close)
               send_item(KIND_PATTERN, SYM_W'($urandom_range(255)), 1'b0, 1'b1);
            nq = $urandom_range(1, 4);
            for (int q = 0; q < nq; q++) begin
               qlen = $urandom_range(0, 12);
               empty_close = (qlen == 0) || ($urandom_range(2) == 0);
               for (int i = 0; i < qlen; i++) begin
                  if ($urandom_range(9) == 0)
                     send_item(KIND_QUERY, SYM_W'($urandom_range(255)), 1'b0, 1'b0);
                  send_item(KIND_QUERY, pick_symbol(), 1'b1, !empty_close && i == qlen - 1);
               end
               if (empty_close)
                  send_item(KIND_QUERY, SYM_W'($urandom_range(255)), 1'b0, 1'b1);
            end
         end else begin
            n = $urandom_range(1, 6);
            repeat (n)
               send_item(req_kind_type'($urandom_range(1)), SYM_W'($urandom_range(255)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
         end
         done = items_sent - start_count;
      end
      steady_flow = 1'b0;
      finish_phase();
   endtask

   initial begin
      pat_len         = 0;
      load_cnt        = 0;
      ovf_flag        = 1'b0;
      items_sent      = 0;
      results_checked = 0;
      failure_count   = 0;
      steady_flow     = 1'b0;
      stall_request   = 0;
      stall_left      = 0;
      longest_stall   = 0;
      for (int i = 0; i < MAX_PATTERN; i++) pat_mem[i] = '0;
      clear_cost_row();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_pattern_overflow();
      test_long_query();
      test_output_backpressure();
      test_random_traffic(170);

      $display("Run covered %0d request transfers and %0d checked distances,",
               items_sent, results_checked);
      $display("with overflow, a long query, empty items and a %0d-cycle output hold-off.",
               longest_stall);
      if (failure_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches in total", failure_count);
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Timeout with %0d distances outstanding", pending_distances.size());
      $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/ede_pkg.sv
rtl/ede_cell.sv
rtl/edit_distance_engine.sv
tb/sv/tb_edit_distance_engine.sv
